// ===== src/mes_pkg.sv =====
package mes_pkg;

    // q4.28 fixed point
    localparam int FRAC_BITS = 28;
    localparam int ITERATION_LIMIT = 50;
    // coordinates map through a shift, so the image size is a power of two
    localparam int IMAGE_SIZE = 1024;
    localparam int IMAGE_LOG2 = $clog2(IMAGE_SIZE);
    localparam int PIX_W = 10;

    localparam logic signed [31:0] RE_OFFSET = -32'sd536870912;   // -2.0
    localparam logic signed [31:0] IM_OFFSET = -32'sd402653184;   // -1.5
    localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000; // 4.0 in q8.56

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = -32'sh8000_0000;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_prod;

    function automatic t_q sat32(input logic signed [37:0] v);
        t_q res;
        if (v > 38'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < 38'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // off + 3*pix*2^28/IMAGE_SIZE
    function automatic t_q map_coord(input logic [PIX_W-1:0] pix, input t_q off);
        logic [11:0] triple;
        logic [35:0] scaled;
        triple = 12'(pix) + {1'b0, pix, 1'b0};
        scaled = 36'(triple) << (FRAC_BITS - IMAGE_LOG2);
        return sat32(38'(off) + $signed({2'b00, scaled}));
    endfunction

endpackage

// ===== src/mandelbrot_escape_shade.sv =====
// channel   | dir | handshake                         | tdata fields (low bit up)
// ----------+-----+-----------------------------------+------------------------------------
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | pixel_x [9:0], pixel_y [19:10], 0
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | shade [7:0]
//
// one item enters per cycle unless the pipeline holds; the stages are one mapping
// stage, then per iteration a multiply stage and an escape test / update stage.
// the last update stage is the output register.
// the whole pipeline holds while a result waits and the sink is not ready.
// synchronous active-low reset clears only the valid bits.
module mandelbrot_escape_shade #(
    parameter int ITERATION_LIMIT = mes_pkg::ITERATION_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // pixel_x [9:0], pixel_y [19:10], zero [23:20]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // shade [7:0]
);

    localparam int L = ITERATION_LIMIT;

    // z state entering each iteration, index L is the result
    logic            r_st_v    [0:L];
    mes_pkg::t_q     r_zx      [0:L];
    mes_pkg::t_q     r_zy      [0:L];
    mes_pkg::t_q     r_cx      [0:L];
    mes_pkg::t_q     r_cy      [0:L];
    logic            r_done    [0:L];
    logic [7:0]      r_shade   [0:L];

    // products of each iteration
    logic            r_pr_v    [0:L-1];
    mes_pkg::t_prod  r_sx      [0:L-1];
    mes_pkg::t_prod  r_sy      [0:L-1];
    mes_pkg::t_prod  r_pxy     [0:L-1];
    mes_pkg::t_q     r_pr_cx   [0:L-1];
    mes_pkg::t_q     r_pr_cy   [0:L-1];
    logic            r_pr_done [0:L-1];
    logic [7:0]      r_pr_shade[0:L-1];

    logic w_en;

    assign w_en            = ~r_st_v[L] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_st_v[L];
    assign o_m_axis_tdata  = r_shade[L];

    // mapping stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_v[0] <= 1'b0;
        end else if (w_en) begin
            r_st_v[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx[0]    <= mes_pkg::map_coord(i_s_axis_tdata[9:0], mes_pkg::RE_OFFSET);
            r_cy[0]    <= mes_pkg::map_coord(i_s_axis_tdata[19:10], mes_pkg::IM_OFFSET);
            r_zx[0]    <= '0;
            r_zy[0]    <= '0;
            r_done[0]  <= 1'b0;
            // a point that never escapes keeps full shade
            r_shade[0] <= 8'hff;
        end
    end

    for (genvar k = 0; k < L; k++) begin : g_iter
        // shade for an item that escapes with count k
        localparam logic [7:0] SHADE = 8'((k * 255) / L);

        logic [63:0]          w_mag;
        logic signed [63:0]   w_diff;
        logic signed [37:0]   w_nx;
        logic signed [37:0]   w_ny;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pr_v[k]    <= 1'b0;
                r_st_v[k+1]  <= 1'b0;
            end else if (w_en) begin
                r_pr_v[k]    <= r_st_v[k];
                r_st_v[k+1]  <= r_pr_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sx[k]       <= r_zx[k] * r_zx[k];
                r_sy[k]       <= r_zy[k] * r_zy[k];
                r_pxy[k]      <= r_zx[k] * r_zy[k];
                r_pr_cx[k]    <= r_cx[k];
                r_pr_cy[k]    <= r_cy[k];
                r_pr_done[k]  <= r_done[k];
                r_pr_shade[k] <= r_shade[k];
            end
        end

        // squares are never negative, so the sum fits unsigned 64 bits
        assign w_mag  = $unsigned(r_sx[k]) + $unsigned(r_sy[k]);
        assign w_diff = r_sx[k] - r_sy[k];
        // part-selects of the signed products are floor shifts
        assign w_nx   = 38'($signed(w_diff[63:28])) + 38'(r_pr_cx[k]);
        assign w_ny   = 38'($signed(r_pxy[k][63:27])) + 38'(r_pr_cy[k]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cx[k+1] <= r_pr_cx[k];
                r_cy[k+1] <= r_pr_cy[k];
                if (r_pr_done[k]) begin
                    r_zx[k+1]    <= r_zx[k];
                    r_zy[k+1]    <= r_zy[k];
                    r_done[k+1]  <= 1'b1;
                    r_shade[k+1] <= r_pr_shade[k];
                end else if (w_mag > mes_pkg::ESCAPE_LIMIT) begin
                    r_zx[k+1]    <= r_zx[k];
                    r_zy[k+1]    <= r_zy[k];
                    r_done[k+1]  <= 1'b1;
                    r_shade[k+1] <= SHADE;
                end else begin
                    r_zx[k+1]    <= mes_pkg::sat32(w_nx);
                    r_zy[k+1]    <= mes_pkg::sat32(w_ny);
                    r_done[k+1]  <= 1'b0;
                    r_shade[k+1] <= r_pr_shade[k];
                end
            end
        end
    end

endmodule

// ===== dv/mandelbrot_escape_shade_test.sv =====
module mandelbrot_escape_shade_test;

    localparam int FRAC = mes_pkg::FRAC_BITS;
    localparam int STEPS = mes_pkg::ITERATION_LIMIT;
    localparam int LATENCY = 2 * STEPS + 1;
    localparam logic [63:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC);
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // pixel_x [9:0], pixel_y [19:10], zero [23:20]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // shade [7:0]

    logic [7:0]  shade_q[$];
    int          fail_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_left = 0;

    mandelbrot_escape_shade i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clamp_q(input longint v);
        longint res;
        if (v > Q_HI) begin
            res = Q_HI;
        end else if (v < Q_LO) begin
            res = Q_LO;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic longint pixel_to_q(input logic [9:0] pix, input longint offset);
        return clamp_q(offset + ((longint'(pix) * 3) << FRAC) / mes_pkg::IMAGE_SIZE);
    endfunction

    // escape-time count of c, scaled to a shade
    function automatic logic [7:0] escape_shade(input logic [9:0] px, input logic [9:0] py);
        longint      cx, cy, zx, zy, sx, sy, nx, ny;
        logic [63:0] mag;
        int          count;
        bit          escaped;
        cx = pixel_to_q(px, -(longint'(2) << FRAC));
        cy = pixel_to_q(py, -((longint'(3) << FRAC) / 2));
        zx = 0;
        zy = 0;
        count = 0;
        escaped = 1'b0;
        for (int i = 0; i < STEPS && !escaped; i++) begin
            sx = zx * zx;
            sy = zy * zy;
            // the sum can reach 2^63, so compare it unsigned
            mag = sx + sy;
            if (mag > ESCAPE_BOUND) begin
                escaped = 1'b1;
            end else begin
                nx = clamp_q(((sx - sy) >>> FRAC) + cx);
                ny = clamp_q(((zx * zy) >>> (FRAC - 1)) + cy);
                zx = nx;
                zy = ny;
                count++;
            end
        end
        return 8'((count * 255) / STEPS);
    endfunction

    task automatic log_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        @(negedge i_clk);
        // each cycle is idle with the set chance
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {4'b0000, py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        shade_q.push_back(escape_shade(px, py));
    endtask

    task automatic stop_sending;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (shade_q.size() == 0) begin
                log_fail($sformatf("shade expected none, got %0d", o_m_axis_tdata));
            end else begin
                want = shade_q.pop_front();
                if (o_m_axis_tdata !== want) begin
                    log_fail($sformatf("shade expected %0d, got %0d", want, o_m_axis_tdata));
                end
            end
        end
    end

    task automatic test_corner_pixels;
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        // c = -2: |z|^2 settles at exactly 4, which must not count as escaped
        send_pixel(10'd0, 10'd512);
        // c near 0, -0.5, -1 and -1.25 never escape
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd341, 10'd512);
        send_pixel(10'd256, 10'd512);
        // cusp at 0.25 and just past it: slow or no escape
        send_pixel(10'd768, 10'd512);
        send_pixel(10'd769, 10'd512);
        send_pixel(10'd770, 10'd512);
        send_pixel(10'h2aa, 10'h155);
        send_pixel(10'h155, 10'h2aa);
        send_pixel(10'd1, 10'd1);
        send_pixel(10'd512, 10'd0);
        send_pixel(10'd600, 10'd700);
    endtask

    task automatic test_random_pixels;
        int idle_set[4] = '{0, 52, 0, 11};
        int stall_set[4] = '{0, 0, 52, 11};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = idle_set[p];
            sink_stall_pct = stall_set[p];
            for (int n = 0; n < 330; n++) begin
                // a third of the items land near the set boundary for long escapes
                if (n % 3 == 0) begin
                    send_pixel(10'($urandom_range(256, 800)), 10'($urandom_range(200, 824)));
                end else begin
                    send_pixel(10'($urandom), 10'($urandom));
                end
            end
        end
    endtask

    task automatic test_sink_hold_off;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 400;
        for (int n = 0; n < 250; n++) begin
            send_pixel(10'($urandom), 10'($urandom));
        end
        sink_stall_pct = 11;
        src_idle_pct = 11;
        for (int n = 0; n < 40; n++) begin
            send_pixel(10'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_pixels;
        test_random_pixels;
        test_sink_hold_off;
        stop_sending;
        while (shade_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mes_pkg.sv
src/mandelbrot_escape_shade.sv
dv/mandelbrot_escape_shade_test.sv
